### hw/rtl/modular_exponentiation_core_macros.svh
// assertion macros for the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define MEXP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("modular exponentiation assertion failed");
// condition that must never be seen outside reset
`define MEXP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `MEXP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define MEXP_ASSERT(lbl, clk, rstn, prop)
`define MEXP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### hw/rtl/mexp_pkg.sv
// types and constants of the modular exponentiation core
package mexp_pkg;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int unsigned IN_DATA_W     = 3 * FIELD_W;
  localparam int unsigned OUT_DATA_W    = FIELD_W;

  // operand choice for the shared modular multiplier
  typedef enum logic [1:0] {
    OPSEL_REDUCE,
    OPSEL_ACC,
    OPSEL_SQR
  } opsel_e;

  typedef struct packed {
    logic   load;
    logic   acc_zero;
    logic   start;
    opsel_e opsel;
    logic   base_wr_red;
    logic   base_wr_sq;
    logic   acc_wr;
    logic   exp_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic mm_done;
  } dp_status_t;

endpackage

### hw/rtl/mexp_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`include "modular_exponentiation_core_macros.svh"

module mexp_modmul
  import mexp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] b_i,
  input  logic [OPERAND_WIDTH-1:0] m_i,
  output logic                     done_o,
  output logic [OPERAND_WIDTH-1:0] result_o
);

  localparam int unsigned SW = OPERAND_WIDTH + 2;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [OPERAND_WIDTH-1:0] a_q, a_d;
  logic [OPERAND_WIDTH-1:0] b_q, b_d;
  logic [OPERAND_WIDTH-1:0] r_q, r_d;

  logic [SW-1:0] sum;
  logic [SW-1:0] m1;
  logic [SW-1:0] m2;
  logic          last;

  assign last = (cnt_q == CNT_W'(OPERAND_WIDTH - 1));
  assign m1   = SW'(m_i);
  assign m2   = SW'({m_i, 1'b0});
  // r < m and b <= m keep 2r + b below 3m
  assign sum  = SW'({r_q, 1'b0}) + (a_q[OPERAND_WIDTH-1] ? SW'(b_q) : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      a_d   = {a_q[OPERAND_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (sum >= m2) begin
        r_d = OPERAND_WIDTH'(sum - m2);
      end else if (sum >= m1) begin
        r_d = OPERAND_WIDTH'(sum - m1);
      end else begin
        r_d = OPERAND_WIDTH'(sum);
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

  `MEXP_ASSERT_NEVER(a_start_busy, clk_i, rst_ni, start_i && busy_q)
  `MEXP_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)
  `MEXP_ASSERT(a_result_reduced, clk_i, rst_ni, done_q |-> (r_q < m_i))

endmodule

### hw/rtl/mexp_datapath.sv
// operand registers, base reduction fix-up and the shared multiplier
module mexp_datapath
  import mexp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic [IN_DATA_W-1:0]     in_data_i,
  output dp_status_t               status_o,
  output logic [OPERAND_WIDTH-1:0] acc_o
);

  logic [OPERAND_WIDTH-1:0] base_q, base_d;
  logic [OPERAND_WIDTH-1:0] exp_q, exp_d;
  logic [OPERAND_WIDTH-1:0] mod_q, mod_d;
  logic [OPERAND_WIDTH-1:0] acc_q, acc_d;
  logic                     neg_q, neg_d;

  logic [OPERAND_WIDTH-1:0] in_base;
  logic [OPERAND_WIDTH-1:0] mag;
  logic [OPERAND_WIDTH-1:0] op_a;
  logic [OPERAND_WIDTH-1:0] op_b;
  logic [OPERAND_WIDTH-1:0] prod;
  logic [OPERAND_WIDTH-1:0] lifted;
  logic                     mm_done;

  assign in_base = in_data_i[OPERAND_WIDTH-1:0];
  // magnitude of the base as a two's complement value
  assign mag     = neg_q ? (~base_q + OPERAND_WIDTH'(1)) : base_q;
  assign lifted  = (prod == '0) ? '0 : (mod_q - prod);

  always_comb begin
    case (cmd_i.opsel)
      OPSEL_REDUCE: begin
        op_a = mag;
        op_b = OPERAND_WIDTH'(1);
      end
      OPSEL_ACC: begin
        op_a = acc_q;
        op_b = base_q;
      end
      OPSEL_SQR: begin
        op_a = base_q;
        op_b = base_q;
      end
      default: begin
        op_a = base_q;
        op_b = base_q;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .a_i      (op_a),
    .b_i      (op_b),
    .m_i      (mod_q),
    .done_o   (mm_done),
    .result_o (prod)
  );

  always_comb begin
    base_d = base_q;
    exp_d  = exp_q;
    mod_d  = mod_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    if (cmd_i.load) begin
      base_d = in_base;
      neg_d  = in_base[OPERAND_WIDTH-1];
      exp_d  = in_data_i[FIELD_W +: OPERAND_WIDTH];
      mod_d  = in_data_i[2*FIELD_W +: OPERAND_WIDTH];
      acc_d  = OPERAND_WIDTH'(1);
    end
    if (cmd_i.acc_zero) begin
      acc_d = '0;
    end
    if (cmd_i.acc_wr) begin
      acc_d = prod;
    end
    if (cmd_i.base_wr_red) begin
      base_d = neg_q ? lifted : prod;
    end
    if (cmd_i.base_wr_sq) begin
      base_d = prod;
    end
    if (cmd_i.exp_shift) begin
      exp_d = {1'b0, exp_q[OPERAND_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
  end

  assign status_o.mod_zero = (mod_q == '0);
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign status_o.mm_done  = mm_done;
  assign acc_o             = acc_q;

endmodule

### hw/rtl/mexp_ctrl.sv
// sequencer for base reduction and the square and multiply loop
module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output logic       out_load_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_REDUCE  = 3'd2;
  localparam logic [2:0] ST_LOOP    = 3'd3;
  localparam logic [2:0] ST_MUL_ACC = 3'd4;
  localparam logic [2:0] ST_MUL_SQR = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o      = '0;
    cmd_o.opsel = OPSEL_SQR;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.mod_zero) begin
          cmd_o.acc_zero = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.opsel = OPSEL_REDUCE;
          state_d     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.mm_done) begin
          cmd_o.base_wr_red = 1'b1;
          state_d           = ST_LOOP;
        end
      end
      ST_LOOP: begin
        // exponent runs dry after at most one pass per operand bit
        if (status_i.exp_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.exp_lsb) begin
          cmd_o.start = 1'b1;
          cmd_o.opsel = OPSEL_ACC;
          state_d     = ST_MUL_ACC;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.opsel = OPSEL_SQR;
          state_d     = ST_MUL_SQR;
        end
      end
      ST_MUL_ACC: begin
        if (status_i.mm_done) begin
          cmd_o.acc_wr = 1'b1;
          cmd_o.start  = 1'b1;
          cmd_o.opsel  = OPSEL_SQR;
          state_d      = ST_MUL_SQR;
        end
      end
      ST_MUL_SQR: begin
        if (status_i.mm_done) begin
          cmd_o.base_wr_sq = 1'b1;
          cmd_o.exp_shift  = 1'b1;
          state_d          = ST_LOOP;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/modular_exponentiation_core.sv
// modular exponentiation core: base to the power exponent modulo modulus
//
// input stream s_axis carries one item per beat: signed base, unsigned
// exponent and modulus. output stream m_axis returns base^exponent mod
// modulus, or 1 when the exponent is zero, and 0 for a zero modulus.
// one item is worked on at a time. the base is first reduced by the shared
// bit-serial modular multiplier, then the exponent is scanned from its
// lowest bit: a set bit costs a multiply and a square, a clear bit a square.
// each multiplication steps through the W multiplier bits (W = operand width),
// one multiplier bit per cycle, so the run time of an item grows with the
// exponent up to its highest set bit. that one multiplier sets the rate.
// the result sits in an output register; the next item is taken as soon as
// the result has moved there, even while the receiver stalls. a stalled
// result holds its beat until taken, and the sequencer then waits before
// loading the following one.
// reset returns the sequencer to idle and empties the output register.
module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // base_value [31:0], exponent [63:32], modulus [95:64]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // power_result [31:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic [OPERAND_WIDTH-1:0] acc;
  logic                     out_free;
  logic                     out_load;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  assign out_free = !out_valid_q || m_axis_tready;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mexp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .status_o  (status),
    .acc_o     (acc)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_DATA_W'(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### tb/testbench.sv
// self-checking testbench for the modular exponentiation core over its operand and result streams
`timescale 1ns / 100ps

module testbench
  import mexp_pkg::*;
();

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 100;

  // packed so that base sits in the lowest bits of the beat
  typedef struct packed {
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] base_value;
  } operands_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // base_value [31:0], exponent [63:32], modulus [95:64]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // power_result [31:0]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  operands_t          pending_operands[$];
  logic [FIELD_W-1:0] expected_powers[$];
  int unsigned        send_idle_pct = 36;
  int unsigned        recv_idle_pct = 64;
  int unsigned        error_count = 0;
  int unsigned        quiet_cycles = 0;

  modular_exponentiation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // right-to-left square and multiply on 64-bit products
  function automatic logic [FIELD_W-1:0] power_mod(operands_t op);
    longint unsigned m;
    longint unsigned b;
    longint unsigned e;
    longint unsigned acc;
    longint unsigned mag;
    longint unsigned r;
    if (op.modulus == '0) begin
      return '0;
    end
    m = {32'd0, op.modulus};
    if (op.base_value[FIELD_W-1]) begin
      mag = {32'd0, ~op.base_value} + 64'd1;
      r = mag % m;
      b = (r == 0) ? 64'd0 : m - r;
    end else begin
      b = {32'd0, op.base_value} % m;
    end
    e = {32'd0, op.exponent};
    acc = 64'd1;
    for (int i = 0; i < OPERAND_WIDTH; i++) begin
      if (e == 0) break;
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc[FIELD_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    $display("%0t: %s: got %08h, expected %08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic queue_operands(logic [FIELD_W-1:0] base_value,
                                logic [FIELD_W-1:0] exponent,
                                logic [FIELD_W-1:0] modulus);
    operands_t op;
    op.base_value = base_value;
    op.exponent   = exponent;
    op.modulus    = modulus;
    pending_operands.push_back(op);
  endtask

  task automatic queue_random_operands(int unsigned count);
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
    int unsigned        bits;
    repeat (count) begin
      case ($urandom_range(3))
        0: base_value = $urandom_range(20) - 10;
        default: base_value = $urandom;
      endcase
      case ($urandom_range(3))
        0: modulus = $urandom_range(1000, 1);
        1: modulus = 32'hFFFF_FFFF - $urandom_range(50);
        default: modulus = $urandom;
      endcase
      if (modulus == '0) modulus = 32'd1;
      // exponent length sets the run time, so most exponents get a random length up to 32 bits
      if ($urandom_range(9) == 0) begin
        exponent = $urandom;
      end else begin
        bits = $urandom_range(32);
        exponent = '0;
        if (bits != 0) begin
          exponent = $urandom & (32'hFFFF_FFFF >> (32 - bits));
          exponent[bits-1] = 1'b1;
        end
      end
      queue_operands(base_value, exponent, modulus);
    end
  endtask

  // sampled on the falling edge so the driver and checker have settled
  task automatic wait_sent();
    while (pending_operands.size() != 0) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_operands.size() != 0 || s_axis_tvalid || expected_powers.size() != 0)
      @(negedge clk_i);
  endtask

  // operand driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_powers.push_back(power_mod(operands_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_operands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= pending_operands.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("result beat with nothing expected", m_axis_tdata, '0);
        end else begin
          logic [FIELD_W-1:0] want;
          want = expected_powers.pop_front();
          if (m_axis_tdata !== want) report_mismatch("power_result", m_axis_tdata, want);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("modular_exponentiation_core test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // edge cases
    queue_operands(32'd7,         32'd0,         32'd1);
    queue_operands(32'hFFFF_FFFF, 32'd5,         32'd0);
    queue_operands(32'd0,         32'd0,         32'd0);
    queue_operands(32'd9,         32'd4,         32'd1);
    queue_operands(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'h8000_0000, 32'd1,         32'd3);
    queue_operands(32'hFFFF_FFFF, 32'd3,         32'd7);
    queue_operands(-32'sd7,       32'd2,         32'd7);
    queue_operands(32'd0,         32'd0,         32'd5);
    queue_operands(32'd0,         32'd5,         32'd5);
    queue_operands(32'd2,         32'd10,        32'd1000);
    queue_operands(32'd2,         32'd31,        32'hFFFF_FFFF);
    queue_operands(32'd3,         32'h8000_0000, 32'hFFFF_FFFB);
    queue_operands(-32'sd2,       32'hFFFF_FFFF, 32'h8000_0000);
    queue_operands(32'd5,         32'd1,         32'd3);
    queue_operands(32'h1234_5678, 32'hFFFF_FFFF, 32'd2);
    queue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    // sender holds off until every result of the edge cases is back
    wait_drained();

    queue_random_operands(94);
    wait_sent();
    send_idle_pct = 64;
    recv_idle_pct = 36;
    queue_random_operands(93);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_operands(93);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("modular_exponentiation_core test passed");
    end else begin
      $display("modular_exponentiation_core test failed");
    end
    $finish;
  end

endmodule
